/* hdl/fpa_pkg.sv */
// Package for the Q24.8 fixed-point ALU: action and status codes,
// pipeline cell payload type and the saturation helper. No dependencies.
`default_nettype none
package fpa_pkg;

  localparam int FracBits = 8;
  // quotient bits needed for floor(2 * |a| * 2^F / |b|)
  localparam int NumW = 33 + FracBits;
  // front (2) + one cell per quotient bit + output register
  localparam int Latency = NumW + 3;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
    ACT_GT = 4'd4, ACT_LT = 4'd5, ACT_GE = 4'd6, ACT_LE = 4'd7,
    ACT_EQ = 4'd8, ACT_NE = 4'd9, ACT_MIN = 4'd10, ACT_MAX = 4'd11,
    ACT_INC = 4'd12, ACT_DEC = 4'd13, ACT_FROM_INT = 4'd14, ACT_TO_INT = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_OVF = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic [31:0]       rem;
    logic [NumW-1:0]   num;
    logic [NumW-1:0]   quo;
    logic [31:0]       den;
    logic [31:0]       res;
    logic              cond;
    logic [1:0]        st;
  } dv_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sd2147483647) begin
      s.val = 32'h7fff_ffff;
      s.ovf = 1'b1;
    end else if (v < -64'sd2147483648) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* hdl/fpa_cell.sv */
// One restoring-division cell: retires one quotient bit per item and
// hands the item to the next cell. Uses fpa_pkg.
`default_nettype none
module fpa_cell (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fpa_pkg::dv_t d_i,
  output fpa_pkg::dv_t     q_o
);

  fpa_pkg::dv_t cell_d, cell_q;
  logic [32:0]  rs;
  logic         ge;

  always_comb begin
    rs = {d_i.rem, d_i.num[fpa_pkg::NumW-1]};
    ge = (rs >= {1'b0, d_i.den});
    cell_d     = d_i;
    cell_d.rem = ge ? 32'(rs - {1'b0, d_i.den}) : rs[31:0];
    cell_d.num = d_i.num << 1;
    cell_d.quo = {d_i.quo[fpa_pkg::NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

/* hdl/fpa_front.sv */
// Front end: registers the item and its product, then works out every
// non-divide result and seeds the divide chain. Uses fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [3:0]         action_i,
  input  wire logic signed [31:0] operand_a_i,
  input  wire logic signed [31:0] operand_b_i,
  output fpa_pkg::dv_t            cell_o
);

  localparam int F = fpa_pkg::FracBits;

  logic               v0_q;
  logic [3:0]         act0_q;
  logic signed [31:0] a0_q, b0_q;
  logic signed [63:0] p0_q;

  logic signed [63:0] ae, be, m, mr, mv, absa, absb;
  fpa_pkg::sat_t      s;
  fpa_pkg::dv_t       c_d, c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act0_q <= action_i;
    a0_q   <= operand_a_i;
    b0_q   <= operand_b_i;
    p0_q   <= 64'(operand_a_i) * 64'(operand_b_i);
  end

  always_comb begin
    ae   = 64'(a0_q);
    be   = 64'(b0_q);
    absa = a0_q[31] ? -ae : ae;
    absb = b0_q[31] ? -be : be;
    // multiply: round magnitude half away from zero
    m  = p0_q[63] ? -p0_q : p0_q;
    mr = (m + (64'sd1 <<< (F - 1))) >>> F;
    mv = p0_q[63] ? -mr : mr;
    s  = '0;

    c_d        = '0;
    c_d.valid  = v0_q;
    c_d.st     = fpa_pkg::ST_OK;
    c_d.num    = fpa_pkg::NumW'(absa[32:0]) << (F + 1);
    c_d.den    = absb[31:0];
    c_d.neg    = a0_q[31] ^ b0_q[31];

    case (act0_q)
      fpa_pkg::ACT_ADD:      s = fpa_pkg::sat32(ae + be);
      fpa_pkg::ACT_SUB:      s = fpa_pkg::sat32(ae - be);
      fpa_pkg::ACT_MUL:      s = fpa_pkg::sat32(mv);
      fpa_pkg::ACT_DIV: begin
        if (b0_q == 32'sd0) begin
          c_d.st = fpa_pkg::ST_DIV0;
        end else begin
          c_d.is_div = 1'b1;
        end
      end
      fpa_pkg::ACT_GT:       c_d.cond = (a0_q > b0_q);
      fpa_pkg::ACT_LT:       c_d.cond = (a0_q < b0_q);
      fpa_pkg::ACT_GE:       c_d.cond = (a0_q >= b0_q);
      fpa_pkg::ACT_LE:       c_d.cond = (a0_q <= b0_q);
      fpa_pkg::ACT_EQ:       c_d.cond = (a0_q == b0_q);
      fpa_pkg::ACT_NE:       c_d.cond = (a0_q != b0_q);
      fpa_pkg::ACT_MIN:      s.val = (a0_q < b0_q) ? a0_q : b0_q;
      fpa_pkg::ACT_MAX:      s.val = (a0_q > b0_q) ? a0_q : b0_q;
      fpa_pkg::ACT_INC:      s = fpa_pkg::sat32(ae + 64'sd1);
      fpa_pkg::ACT_DEC:      s = fpa_pkg::sat32(ae - 64'sd1);
      fpa_pkg::ACT_FROM_INT: s = fpa_pkg::sat32(ae <<< F);
      fpa_pkg::ACT_TO_INT:   s.val = 32'(a0_q >>> F);
      default:               s = '0;
    endcase

    c_d.res = s.val;
    if (s.ovf) begin
      c_d.st = fpa_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else begin
      c_q <= c_d;
    end
  end

  assign cell_o = c_q;

endmodule
`default_nettype wire

/* hdl/fixed_point_alu_q24_8.sv */
// Top level of the Q24.8 fixed-point ALU: front end, chain of divide
// cells and output register. Uses fpa_pkg, fpa_front, fpa_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start_i / busy_o   | action_i, operand_a_i, operand_b_i
//  result   | done_o (1 cycle)   | result_value_o, condition_o, status_o
//
// One item per cycle; busy_o stays low. Every item's result passes through
// the front-end registers, the divide chain of one cell per quotient bit
// and the output register; other actions ride along the same chain.
// Reset clears the chain registers; results leave in acceptance order.
`default_nettype none
module fixed_point_alu_q24_8 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic [3:0]         action_i,
  input  wire logic signed [31:0] operand_a_i,
  input  wire logic signed [31:0] operand_b_i,
  output      logic               done_o,
  output      logic signed [31:0] result_value_o,
  output      logic               condition_o,
  output      logic [1:0]         status_o
);

  localparam int N = fpa_pkg::NumW;

  fpa_pkg::dv_t chain [0:N];

  logic [N:0]         qr;
  logic signed [63:0] dv;
  fpa_pkg::sat_t      ds;
  logic               done_q;
  logic [31:0]        res_q;
  logic               cond_q;
  logic [1:0]         st_q;
  logic [31:0]        res_d;
  logic [1:0]         st_d;

  assign busy_o = 1'b0;

  fpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i & ~busy_o),
    .action_i   (action_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .cell_o     (chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .d_i   (chain[i]),
      .q_o   (chain[i+1])
    );
  end

  // quotient holds floor(2n/d); round half away = (Q + 1) >> 1
  always_comb begin
    qr    = ({1'b0, chain[N].quo} + 1'b1) >> 1;
    dv    = chain[N].neg ? -64'(qr) : 64'(qr);
    ds    = fpa_pkg::sat32(dv);
    res_d = chain[N].res;
    st_d  = chain[N].st;
    if (chain[N].is_div) begin
      res_d = ds.val;
      st_d  = ds.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cond_q <= chain[N].cond;
    st_q   <= st_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign condition_o    = cond_q;
  assign status_o       = st_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, fpa_pkg::Latency))
    else $error("result without matching item");
  a_div0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == fpa_pkg::ST_DIV0) |-> (result_value_o == 32'd0 && !condition_o))
    else $error("divide by zero result not cleared");
  a_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && condition_o) |-> (result_value_o == 32'd0 && status_o == fpa_pkg::ST_OK))
    else $error("comparison result carries value or status");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != 2'd3))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the Q24.8 fixed-point ALU: directed corner items, then random
// items, under several sender idle patterns. Depends on fpa_pkg and the RTL top.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] val;
    logic        cond;
    logic [1:0]  st;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int errors;
    int n_items;
    int n_checked;

    function alu_res_t clip(input logic signed [63:0] v);
      alu_res_t r;
      r = '0;
      if (v > 64'sd2147483647) begin
        r.val = 32'h7fff_ffff;
        r.st = ST_OVF;
      end else if (v < -64'sd2147483648) begin
        r.val = 32'h8000_0000;
        r.st = ST_OVF;
      end else begin
        r.val = v[31:0];
      end
      return r;
    endfunction

    // magnitude limited so the sign stays meaningful inside 64 bits
    function logic signed [63:0] with_sign(input logic [63:0] mag, input logic neg);
      if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
      return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function alu_res_t compute(input action_e act, input logic signed [31:0] a32,
                               input logic signed [31:0] b32);
      logic signed [63:0] a, b, p;
      logic [63:0] ma, mb, m, q;
      alu_res_t r;
      a = a32;
      b = b32;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r = '0;
      case (act)
        ACT_ADD: r = clip(a + b);
        ACT_SUB: r = clip(a - b);
        ACT_MUL: begin
          p = a * b;
          m = p < 0 ? -p : p;
          m = (m + (64'd1 << (FracBits - 1))) >> FracBits;
          r = clip(with_sign(m, p < 0));
        end
        ACT_DIV: begin
          if (b == 0) begin
            r.st = ST_DIV0;
          end else begin
            m = ma << FracBits;
            q = (2 * m + mb) / (2 * mb);
            r = clip(with_sign(q, (a < 0) != (b < 0)));
          end
        end
        ACT_GT: r.cond = a > b;
        ACT_LT: r.cond = a < b;
        ACT_GE: r.cond = a >= b;
        ACT_LE: r.cond = a <= b;
        ACT_EQ: r.cond = a == b;
        ACT_NE: r.cond = a != b;
        ACT_MIN: r.val = (a < b) ? a32 : b32;
        ACT_MAX: r.val = (a > b) ? a32 : b32;
        ACT_INC: r = clip(a + 1);
        ACT_DEC: r = clip(a - 1);
        ACT_FROM_INT: r = clip(with_sign(ma << FracBits, a < 0));
        default: r.val = a32 >>> FracBits;
      endcase
      return r;
    endfunction

    function void note_item(input action_e act, input logic [31:0] a,
                            input logic [31:0] b);
      pending.push_back(compute(act, a, b));
      n_items++;
    endfunction

    function void check_result(input logic [31:0] val, input logic cond,
                               input logic [1:0] st);
      alu_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value=%h", val);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (val !== e.val) begin
        $error("result_value expected %h actual %h", e.val, val);
        errors++;
      end
      if (cond !== e.cond) begin
        $error("condition expected %b actual %b", e.cond, cond);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [3:0] action_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic busy_o, done_o, condition_o;
  logic signed [31:0] result_value_o;
  logic [1:0] status_o;

  alu_scoreboard sb = new();
  int idle_pct = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 200000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fixed_point_alu_q24_8 uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .operand_a_i, .operand_b_i,
    .done_o, .result_value_o, .condition_o, .status_o
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start_i && !busy_o)
      sb.note_item(action_e'(action_i), operand_a_i, operand_b_i);
    if (rst_ni && done_o) sb.check_result(result_value_o, condition_o, status_o);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // one item: optional random idle, then hold start until accepted
  task automatic send_item(input logic [3:0] act, input logic [31:0] a,
                           input logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(4095) - 2048;
      2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      3: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h100;
          default: return 32'hffff_ff00;
        endcase
      end
      default: return $signed(32'($urandom)) >>> $urandom_range(31);
    endcase
  endfunction

  localparam logic [31:0] MaxV = 32'h7fff_ffff;
  localparam logic [31:0] MinV = 32'h8000_0000;

  initial begin
    int phase;
    int k;
    action_e act;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_ADD, MaxV, 32'h1);
    send_item(ACT_SUB, MinV, 32'h1);
    send_item(ACT_MUL, MaxV, MaxV);
    send_item(ACT_MUL, MinV, MaxV);
    send_item(ACT_MUL, 32'h180, 32'hffff_ff80);  // 1.5 * -0.5: exact product, no rounding
    send_item(ACT_MUL, 32'h1, 32'h80);
    send_item(ACT_DIV, 32'h100, 32'h0);
    send_item(ACT_DIV, MinV, 32'hffff_ffff);
    send_item(ACT_DIV, 32'h1, 32'h200);
    send_item(ACT_DIV, MinV, MinV);
    send_item(ACT_GT, 32'h5, 32'h5);
    send_item(ACT_LT, MinV, MaxV);
    send_item(ACT_GE, 32'h5, 32'h5);
    send_item(ACT_LE, MaxV, MinV);
    send_item(ACT_EQ, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ACT_NE, 32'h0, 32'h1);
    send_item(ACT_MIN, 32'h7, 32'h7);
    send_item(ACT_MAX, MinV, MaxV);
    send_item(ACT_INC, MaxV, 32'h0);
    send_item(ACT_DEC, MinV, 32'h0);
    send_item(ACT_FROM_INT, 32'h0080_0000, 32'h0);
    send_item(ACT_FROM_INT, MinV, 32'h0);
    send_item(ACT_TO_INT, 32'hffff_ff01, 32'h0);
    send_item(ACT_TO_INT, MaxV, MaxV);

    // idle patterns: none, sender 55%, 22%, then none again
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      for (k = 0; k < 95; k++) begin
        act = action_e'($urandom_range(15));
        send_item(act, rand_operand(), rand_operand());
      end
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);

    $display("covered %0d items across all actions, %0d results checked",
             sb.n_items, sb.n_checked);
    $display("idle patterns: none, 55%% and 22%% sender gaps");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* fixed_point_alu_q24_8.f */
hdl/fpa_pkg.sv
hdl/fpa_cell.sv
hdl/fpa_front.sv
hdl/fixed_point_alu_q24_8.sv
sim/tb_top.sv
